// ===== src/mqpd_pkg.sv =====
// mqpd_pkg: sizes, codes and record types of the multi queue priority deque
// no dependencies; imported by multi_queue_priority_deque_core
`default_nettype none

package mqpd_pkg;

    // geometry
    localparam int NUM_QUEUES  = 32;
    localparam int QUEUE_DEPTH = 8;

    // field widths fixed by the interface
    localparam int REQ_Q_W   = 5;
    localparam int ID_W      = 16;
    localparam int CFG_W     = 4;
    localparam int OUT_CNT_W = 4;
    localparam int CODE_W    = 2;

    // derived internal widths
    localparam int QW      = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int PW      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int CMP_W   = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int ENT_NUM = NUM_QUEUES * QUEUE_DEPTH;
    localparam int ADDR_W  = (ENT_NUM > 1) ? $clog2(ENT_NUM) : 1;

    localparam logic [CFG_W-1:0] CAPACITY_RESET = CFG_W'(5);

    // result codes
    localparam logic [CODE_W-1:0] CODE_ADDED = 2'd0;
    localparam logic [CODE_W-1:0] CODE_FULL  = 2'd1;
    localparam logic [CODE_W-1:0] CODE_TAKEN = 2'd2;
    localparam logic [CODE_W-1:0] CODE_EMPTY = 2'd3;

    // request kinds
    localparam logic REQ_ADD  = 1'b0;
    localparam logic REQ_TAKE = 1'b1;

    typedef struct packed {
        logic [PW-1:0]    head;
        logic [CNT_W-1:0] count;
    } qstate_t;

    typedef struct packed {
        logic [ID_W-1:0] id;
        logic            urgent;
    } entry_t;

    // circular pointer helpers
    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
        ptr_dec = (p == '0) ? PW'(QUEUE_DEPTH - 1) : p - PW'(1);
    endfunction

    // sum stays below twice the depth, so one compare and subtract wraps it
    function automatic logic [PW-1:0] ptr_add(input logic [PW-1:0] p,
                                              input logic [CNT_W-1:0] n);
        logic [PW+CNT_W-1:0] s;
        s = (PW+CNT_W)'(p) + (PW+CNT_W)'(n);
        if (s >= (PW+CNT_W)'(QUEUE_DEPTH))
            s = s - (PW+CNT_W)'(QUEUE_DEPTH);
        ptr_add = s[PW-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== src/multi_queue_priority_deque_core.sv =====
// multi_queue_priority_deque_core: bounded per-queue deques kept in block memories
// depends on mqpd_pkg for sizes, codes and record types
//
// Keeps NUM_QUEUES bounded queues of (id, urgent) entries. Each request beat on the
// input stream names a queue and either adds an entry or takes the head entry; every
// request gives exactly one result beat. An urgent add is pushed at the head (newest
// urgent first), a regular add goes to the tail; an add to a queue already holding
// 'capacity' entries (saturated at QUEUE_DEPTH) is rejected. Each queue is a circular
// buffer: a per-queue head pointer and count live in a small synchronous memory (with
// one valid bit per queue so that reset empties all queues at once), and the entries
// live in a second synchronous memory of NUM_QUEUES*QUEUE_DEPTH words. A request is handled
// in two steps: the queue's head and count are read, then the block decides, writes the
// entry and writes back the new head and count. A successful take adds a third step for
// the entry read, but the next request is accepted during that step, so no new request
// is taken before the previous one has been decided; the pace is set by the read-then-write
// of the queue state memory. The result sits in an output register so a stalled consumer
// only holds the block once a second result is ready. The capacity register is written
// through the cfg channel, which is always ready, and is meant to be changed only while no
// request is in flight. There is no clearing pass after reset.
`default_nettype none

module multi_queue_priority_deque_core
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,

    // request stream
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [23:0]                 s_tdata,   // queue_index, entry_id, urgent, pad
    input  wire logic                        s_tuser,   // req_type

    // result stream
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [23:0]                      m_tdata,   // taken_id, taken_urgent, queue_count, pad
    output logic [mqpd_pkg::CODE_W-1:0]      m_tuser,   // result_code

    // capacity register write
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [mqpd_pkg::CFG_W-1:0]  cfg_data
);
    import mqpd_pkg::*;

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;   // waiting for a request beat
    localparam logic [1:0] S_RD   = 2'd1;   // queue state read back, decide and write
    localparam logic [1:0] S_TK   = 2'd2;   // taken entry read back, emit result

    logic [1:0] state_reg, state_next;

    // capacity register
    logic [CFG_W-1:0] cap_reg;

    // latched request
    logic             req_take_reg;
    logic [REQ_Q_W-1:0] req_q_reg;
    logic [ID_W-1:0]  req_id_reg;
    logic             req_urg_reg;

    // queue state memory, with one valid bit per queue cleared at reset
    qstate_t          qs_mem [NUM_QUEUES];
    logic [NUM_QUEUES-1:0] qv_reg;
    qstate_t          qs_rd_reg;
    logic             qs_vld_rd_reg;
    logic             qs_we;
    qstate_t          qs_wdata;

    // entry memory
    entry_t           ent_mem [ENT_NUM];
    entry_t           ent_rd_reg;
    logic             ent_we;
    logic             ent_re;
    logic [PW-1:0]    ent_slot;
    logic [ADDR_W-1:0] ent_addr;
    entry_t           ent_wdata;

    // count left after a take, held until the taken result is loaded
    logic [CNT_W-1:0] tk_cnt_reg, tk_cnt_next;

    // output register
    logic              out_valid_reg;
    logic [CODE_W-1:0] out_code_reg;
    logic [ID_W-1:0]   out_id_reg;
    logic              out_urg_reg;
    logic [CNT_W-1:0]  out_cnt_reg;
    logic              out_load;
    logic [CODE_W-1:0] out_code_next;
    logic [ID_W-1:0]   out_id_next;
    logic              out_urg_next;
    logic [CNT_W-1:0]  out_cnt_next;
    logic              out_free;

    // decision terms
    logic              accept;
    logic              req_oor;
    logic [PW-1:0]     cur_head;
    logic [CNT_W-1:0]  cur_cnt;
    logic [CMP_W-1:0]  eff_cap;
    logic              is_full;
    logic              take_ok;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;

    // queue index beyond the configured number of queues
    assign req_oor = ({1'b0, req_q_reg} >= (REQ_Q_W+1)'(NUM_QUEUES));

    // a queue never written reads as empty with head at slot zero
    assign cur_head = qs_vld_rd_reg ? qs_rd_reg.head  : '0;
    assign cur_cnt  = qs_vld_rd_reg ? qs_rd_reg.count : '0;

    assign eff_cap = (CMP_W'(cap_reg) > CMP_W'(QUEUE_DEPTH)) ? CMP_W'(QUEUE_DEPTH)
                                                             : CMP_W'(cap_reg);
    assign is_full = CMP_W'(cur_cnt) >= eff_cap;
    assign take_ok = req_take_reg && !req_oor && (cur_cnt != '0);

    always_comb
    begin
        state_next    = state_reg;
        s_tready      = 1'b0;
        qs_we         = 1'b0;
        qs_wdata      = qs_rd_reg;
        ent_we        = 1'b0;
        ent_re        = 1'b0;
        ent_slot      = cur_head;
        ent_wdata     = '{id: req_id_reg, urgent: req_urg_reg};
        tk_cnt_next   = tk_cnt_reg;
        out_load      = 1'b0;
        out_code_next = CODE_ADDED;
        out_id_next   = '0;
        out_urg_next  = 1'b0;
        out_cnt_next  = '0;

        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                    state_next = S_RD;
            end

            S_RD:
            begin
                if (take_ok)
                begin
                    // pop the head; entry data arrives next cycle
                    ent_re         = 1'b1;
                    ent_slot       = cur_head;
                    qs_we          = 1'b1;
                    qs_wdata.head  = ptr_inc(cur_head);
                    qs_wdata.count = cur_cnt - CNT_W'(1);
                    tk_cnt_next    = cur_cnt - CNT_W'(1);
                    state_next     = S_TK;
                end
                else if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                    if (req_oor)
                    begin
                        out_code_next = req_take_reg ? CODE_EMPTY : CODE_FULL;
                    end
                    else if (req_take_reg)
                    begin
                        out_code_next = CODE_EMPTY;
                    end
                    else if (is_full)
                    begin
                        out_code_next = CODE_FULL;
                        out_cnt_next  = cur_cnt;
                    end
                    else
                    begin
                        // urgent goes in front of the head, regular after the tail
                        ent_we         = 1'b1;
                        ent_slot       = req_urg_reg ? ptr_dec(cur_head)
                                                     : ptr_add(cur_head, cur_cnt);
                        qs_we          = 1'b1;
                        qs_wdata.head  = req_urg_reg ? ptr_dec(cur_head) : cur_head;
                        qs_wdata.count = cur_cnt + CNT_W'(1);
                        out_code_next  = CODE_ADDED;
                        out_cnt_next   = cur_cnt + CNT_W'(1);
                    end
                end
            end

            S_TK:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    out_code_next = CODE_TAKEN;
                    out_id_next   = ent_rd_reg.id;
                    out_urg_next  = ent_rd_reg.urgent;
                    out_cnt_next  = tk_cnt_reg;
                    // next request overlaps with delivery of this result
                    s_tready      = 1'b1;
                    state_next    = s_tvalid ? S_RD : S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign ent_addr = ADDR_W'(req_q_reg[QW-1:0]) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(ent_slot);

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cap_reg       <= CAPACITY_RESET;
            qv_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                cap_reg <= cfg_data;
            if (qs_we)
                qv_reg[req_q_reg[QW-1:0]] <= 1'b1;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_take_reg  <= s_tuser;
            req_q_reg     <= s_tdata[4:0];
            req_id_reg    <= s_tdata[20:5];
            req_urg_reg   <= s_tdata[21];
            qs_vld_rd_reg <= qv_reg[s_tdata[QW-1:0]];
        end
        tk_cnt_reg <= tk_cnt_next;
        if (out_load)
        begin
            out_code_reg <= out_code_next;
            out_id_reg   <= out_id_next;
            out_urg_reg  <= out_urg_next;
            out_cnt_reg  <= out_cnt_next;
        end
    end

    // queue state memory
    always_ff @(posedge clk)
    begin
        if (qs_we)
            qs_mem[req_q_reg[QW-1:0]] <= qs_wdata;
        if (accept)
            qs_rd_reg <= qs_mem[s_tdata[QW-1:0]];
    end

    // entry memory
    always_ff @(posedge clk)
    begin
        if (ent_we)
            ent_mem[ent_addr] <= ent_wdata;
        if (ent_re)
            ent_rd_reg <= ent_mem[ent_addr];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_code_reg;
    assign m_tdata  = {3'b000, OUT_CNT_W'(out_cnt_reg), out_urg_reg, out_id_reg};

    // a taken-entry cycle follows a pop decision, or holds while the result waits
    a_tk_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TK) |-> (($past(state_reg) == S_RD) || ($past(state_reg) == S_TK)))
        else $error("take completion without a preceding pop");

    // a written-back count never exceeds the queue depth
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        qs_we |-> (qs_wdata.count <= CNT_W'(QUEUE_DEPTH)))
        else $error("queue count beyond depth");

    // only a take reports an id or flag
    a_taken_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != CODE_TAKEN)) |-> ((out_id_reg == '0) && !out_urg_reg))
        else $error("id reported on a result that took nothing");

    // entry memory is never read and written in the same cycle
    a_ent_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(ent_we && ent_re))
        else $error("entry memory read and write collide");

endmodule

`default_nettype wire
